// ----- rtl/idle_state_governor_macros.svh -----
// Assertion helpers for the idle-state governor.
`ifndef IDLE_STATE_GOVERNOR_MACROS_SVH
`define IDLE_STATE_GOVERNOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ISG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ISG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/isg_pkg.sv -----
package isg_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [2:0]  MAX_LEVELS    = 3'd4;
    localparam logic [15:0] C1_LATENCY    = 16'd1;
    localparam logic signed [33:0] SLEEP_OVERHEAD = 34'sd4;
    localparam logic signed [33:0] C1_SLEEP       = 34'sh0_FFFF_FFFF;
    localparam logic [31:0] TIMER24_MASK  = 32'h00FF_FFFF;
    localparam logic [4:0]  SHIFT_MAX     = 5'd31;
    localparam logic [7:0]  CNT_MAX       = 8'd255;
    localparam logic [7:0]  THR_C1        = 8'd5;
    localparam logic [7:0]  THR_C2        = 8'd15;
    localparam logic [7:0]  THR_C3        = 8'd1;

    typedef enum logic [2:0] {
        CFG_TIMER_32BIT  = 3'd0,
        CFG_BM_CHECK     = 3'd1,
        CFG_LEVEL_COUNT  = 3'd2,
        CFG_LATENCY_L1   = 3'd3,
        CFG_LATENCY_L2   = 3'd4,
        CFG_LATENCY_L3   = 3'd5,
        CFG_DEEP_MASK    = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_C1 = 2'd0,
        KIND_C2 = 2'd1,
        KIND_C3 = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        RELOAD_NONE = 2'd0,
        RELOAD_ZERO = 2'd1,
        RELOAD_ONE  = 2'd2
    } t_reload;

    function automatic t_kind level_kind(input logic [1:0] lv, input logic [2:0] mask);
        t_kind k;
        if (lv == 2'd0) begin
            k = KIND_C1;
        end else if (mask[lv - 2'd1]) begin
            k = KIND_C3;
        end else begin
            k = KIND_C2;
        end
        return k;
    endfunction

    function automatic logic [15:0] level_latency(input logic [1:0] lv,
                                                  input logic [15:0] lat1,
                                                  input logic [15:0] lat2,
                                                  input logic [15:0] lat3);
        logic [15:0] l;
        case (lv)
            2'd1:    l = lat1;
            2'd2:    l = lat2;
            2'd3:    l = lat3;
            default: l = C1_LATENCY;
        endcase
        return l;
    endfunction

endpackage

// ----- rtl/isg_in_if.sv -----
interface isg_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] timer_start;
    logic [31:0] timer_end;
    logic        bus_master_active;
    logic [15:0] ms_since_check;

    modport source (output valid, timer_start, timer_end, bus_master_active,
                    ms_since_check, input ready);
    modport sink   (input valid, timer_start, timer_end, bus_master_active,
                    ms_since_check, output ready);
endinterface

// ----- rtl/isg_out_if.sv -----
interface isg_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         next_level;
    logic signed [32:0] sleep_ticks;
    logic               clear_bus_master;
    logic [1:0]         reload_action;
    logic               deep_unsupported;

    modport source (output valid, next_level, sleep_ticks, clear_bus_master,
                    reload_action, deep_unsupported, input ready);
    modport sink   (input valid, next_level, sleep_ticks, clear_bus_master,
                    reload_action, deep_unsupported, output ready);
endinterface

// ----- rtl/idle_state_governor.sv -----
// Pipeline: an accepted input beat reaches its result beat through the input
// register, then the result register.
// Throughput: one beat per cycle when the output is not stalled; the level/counter/
// history update is a single combinational pass between input and result registers.
// Reset (synchronous, active low): level C1, counter and history zero, registers
// at defaults (24-bit timer, one level), both pipeline stages empty.
`include "idle_state_governor_macros.svh"

module idle_state_governor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [isg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [isg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    isg_in_if.sink                           i_in_ch,
    isg_out_if.source                        o_out_ch
);

    logic        r_timer32;
    logic        r_bm_check;
    logic [2:0]  r_level_count;
    logic [15:0] r_lat1;
    logic [15:0] r_lat2;
    logic [15:0] r_lat3;
    logic [2:0]  r_deep_mask;

    logic [1:0]  r_lv;
    logic [7:0]  r_cnt;
    logic [31:0] r_hist;

    logic        r_in_valid;
    logic [31:0] r_in_t1;
    logic [31:0] r_in_t2;
    logic        r_in_bm;
    logic [15:0] r_in_ms;

    logic               r_out_valid;
    logic [1:0]         r_out_level;
    logic signed [32:0] r_out_sleep;
    logic               r_out_clr;
    logic [1:0]         r_out_reload;
    logic               r_out_unsup;

    logic        adv;
    logic        fire;
    logic        in_acc;

    logic [1:0]            n_lv;
    logic [7:0]            n_cnt;
    logic [31:0]           n_hist;
    logic signed [33:0]    sleep;
    logic                  clr;
    isg_pkg::t_reload      reload;
    logic                  unsup;

    logic                  done;
    logic                  promo;
    isg_pkg::t_kind        kind;
    isg_pkg::t_kind        next_kind;
    logic [2:0]            count;
    logic [4:0]            sh;
    logic [31:0]           diff;
    logic [31:0]           wrapped;
    logic [31:0]           elapsed;
    logic [15:0]           lat_cur;
    logic [15:0]           lat_next;
    logic [15:0]           lat_prev;
    logic [7:0]            thr;

    assign adv    = !r_out_valid || o_out_ch.ready;
    assign fire   = r_in_valid && adv;
    assign i_in_ch.ready = !r_in_valid || adv;
    assign in_acc = i_in_ch.valid && i_in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer32     <= 1'b0;
            r_bm_check    <= 1'b0;
            r_level_count <= 3'd1;
            r_lat1        <= '0;
            r_lat2        <= '0;
            r_lat3        <= '0;
            r_deep_mask   <= '0;
        end else if (i_cfg_we) begin
            case (isg_pkg::t_cfg_idx'(i_cfg_idx))
                isg_pkg::CFG_TIMER_32BIT: r_timer32     <= i_cfg_data[0];
                isg_pkg::CFG_BM_CHECK:    r_bm_check    <= i_cfg_data[0];
                isg_pkg::CFG_LEVEL_COUNT: r_level_count <= i_cfg_data[2:0];
                isg_pkg::CFG_LATENCY_L1:  r_lat1        <= i_cfg_data;
                isg_pkg::CFG_LATENCY_L2:  r_lat2        <= i_cfg_data;
                isg_pkg::CFG_LATENCY_L3:  r_lat3        <= i_cfg_data;
                isg_pkg::CFG_DEEP_MASK:   r_deep_mask   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_t1 <= i_in_ch.timer_start;
            r_in_t2 <= i_in_ch.timer_end;
            r_in_bm <= i_in_ch.bus_master_active;
            r_in_ms <= i_in_ch.ms_since_check;
        end
    end

    // elapsed ticks; on wrap, (end - start - 1), masked to 24 bits unless the timer is 32-bit
    always_comb begin
        diff    = r_in_t2 - r_in_t1;
        wrapped = diff - 32'd1;
        if (r_in_t2 >= r_in_t1) begin
            elapsed = diff;
        end else if (r_timer32) begin
            elapsed = wrapped;
        end else begin
            elapsed = wrapped & isg_pkg::TIMER24_MASK;
        end
    end

    always_comb begin
        kind      = isg_pkg::level_kind(r_lv, r_deep_mask);
        next_kind = isg_pkg::level_kind(r_lv + 2'd1, r_deep_mask);
        lat_cur   = isg_pkg::level_latency(r_lv, r_lat1, r_lat2, r_lat3);
        lat_next  = isg_pkg::level_latency(r_lv + 2'd1, r_lat1, r_lat2, r_lat3);
        lat_prev  = isg_pkg::level_latency(r_lv - 2'd1, r_lat1, r_lat2, r_lat3);
        count     = (r_level_count < isg_pkg::MAX_LEVELS) ? r_level_count
                                                          : isg_pkg::MAX_LEVELS;
        sh        = (r_in_ms > 16'(isg_pkg::SHIFT_MAX)) ? isg_pkg::SHIFT_MAX
                                                         : r_in_ms[4:0];
        case (kind)
            isg_pkg::KIND_C1: thr = isg_pkg::THR_C1;
            isg_pkg::KIND_C2: thr = isg_pkg::THR_C2;
            default:          thr = isg_pkg::THR_C3;
        endcase
    end

    always_comb begin
        n_lv   = r_lv;
        n_cnt  = r_cnt;
        n_hist = r_hist;
        sleep  = '0;
        clr    = 1'b0;
        reload = isg_pkg::RELOAD_NONE;
        unsup  = 1'b0;
        done   = 1'b0;
        promo  = 1'b0;

        if (r_bm_check) begin
            n_hist = r_hist << sh;
            if (r_in_bm) begin
                n_hist[0] = 1'b1;
                clr       = 1'b1;
                if (kind == isg_pkg::KIND_C3) begin
                    reload = isg_pkg::RELOAD_ZERO;
                    if (r_lv != 2'd0) begin
                        n_lv = r_lv - 2'd1;
                    end
                    n_cnt = '0;
                    done  = 1'b1;
                end
            end
        end

        if (!done && kind == isg_pkg::KIND_C3 && !r_bm_check) begin
            unsup = 1'b1;
            done  = 1'b1;
        end

        if (!done) begin
            if (kind == isg_pkg::KIND_C1) begin
                sleep = isg_pkg::C1_SLEEP;
            end else begin
                sleep = $signed({2'b00, elapsed}) - $signed({18'd0, lat_cur})
                        - isg_pkg::SLEEP_OVERHEAD;
            end

            if ((({1'b0, r_lv} + 3'd1) < count) &&
                (sleep > $signed({18'd0, lat_next}))) begin
                promo = 1'b1;
                if (r_cnt != isg_pkg::CNT_MAX) begin
                    n_cnt = r_cnt + 8'd1;
                end
                if (r_cnt > thr &&
                    !(next_kind == isg_pkg::KIND_C3 && n_hist != '0)) begin
                    n_lv  = r_lv + 2'd1;
                    n_cnt = '0;
                    if (next_kind == isg_pkg::KIND_C3) begin
                        reload = isg_pkg::RELOAD_ONE;
                    end
                end
            end

            if (!promo && r_lv != 2'd0 && sleep < $signed({18'd0, lat_prev})) begin
                n_lv  = r_lv - 2'd1;
                n_cnt = '0;
                if (kind == isg_pkg::KIND_C3) begin
                    reload = isg_pkg::RELOAD_ZERO;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv   <= '0;
            r_cnt  <= '0;
            r_hist <= '0;
        end else if (fire) begin
            r_lv   <= n_lv;
            r_cnt  <= n_cnt;
            r_hist <= n_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_level  <= n_lv;
            r_out_sleep  <= sleep[32:0];
            r_out_clr    <= clr;
            r_out_reload <= reload;
            r_out_unsup  <= unsup;
        end
    end

    assign o_out_ch.valid            = r_out_valid;
    assign o_out_ch.next_level       = r_out_level;
    assign o_out_ch.sleep_ticks      = r_out_sleep;
    assign o_out_ch.clear_bus_master = r_out_clr;
    assign o_out_ch.reload_action    = r_out_reload;
    assign o_out_ch.deep_unsupported = r_out_unsup;

    `ISG_ASSERT_NOW(a_level_in_range, 1'b1, r_lv <= 2'(isg_pkg::MAX_LEVELS - 3'd1), "level beyond the maximum")
    `ISG_ASSERT_NOW(a_unsup_no_clear, r_out_valid, !(r_out_unsup && r_out_clr), "unsupported and clear together")
    `ISG_ASSERT_NEXT(a_one_step, fire, (r_lv == $past(r_lv)) || (r_lv == $past(r_lv) + 2'd1) || (r_lv == $past(r_lv) - 2'd1), "level moved by more than one")
    `ISG_ASSERT_NEXT(a_hold_level, !fire, $stable(r_lv) && $stable(r_cnt) && $stable(r_hist), "state changed without a beat")

endmodule
